### rtl/bss_pkg.sv
// Shared types and constants for the bounded sequence store.
`timescale 1ns / 1ps

package bss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 7;
    localparam int WORD_W       = 32;
    localparam int STAT_W       = 2;
    localparam int COUNT_W      = 7;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_INSERT     = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_READ_AT    = 4'd6,
        OP_FRONT      = 4'd7,
        OP_BACK       = 4'd8,
        OP_SORT       = 4'd9,
        OP_CLEAR      = 4'd10
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_stat;

    // memory address sources
    typedef enum logic [3:0] {
        A_ZERO   = 4'd0,
        A_LAST   = 4'd1,
        A_POS    = 4'd2,
        A_OCC    = 4'd3,
        A_AT     = 4'd4,
        A_IDX    = 4'd5,
        A_IDX_M1 = 4'd6,
        A_IDX_P1 = 4'd7,
        A_I      = 4'd8
    } t_asel;

    typedef enum logic [1:0] {
        D_WORD = 2'd0,
        D_RD   = 2'd1,
        D_KEY  = 2'd2
    } t_wdsel;

    typedef enum logic [2:0] {
        IX_HOLD = 3'd0,
        IX_OCC  = 3'd1,
        IX_AT   = 3'd2,
        IX_I    = 3'd3,
        IX_DEC  = 3'd4,
        IX_INC  = 3'd5
    } t_idxop;

    typedef enum logic [1:0] {
        AT_HOLD = 2'd0,
        AT_ZERO = 2'd1,
        AT_POS  = 2'd2
    } t_atop;

    typedef enum logic [1:0] {
        I_HOLD = 2'd0,
        I_ONE  = 2'd1,
        I_INC  = 2'd2
    } t_iop;

    typedef enum logic [1:0] {
        OC_HOLD = 2'd0,
        OC_INC  = 2'd1,
        OC_DEC  = 2'd2,
        OC_CLR  = 2'd3
    } t_occop;

    // controller -> datapath
    typedef struct packed {
        logic   req_ld;
        logic   stat_ld;
        t_stat  stat;
        logic   rd_en;
        t_asel  rd_sel;
        logic   wr_en;
        t_asel  wr_sel;
        t_wdsel wd_sel;
        t_idxop idx_op;
        t_atop  at_op;
        t_iop   i_op;
        logic   key_ld;
        logic   val_ld;
        t_occop occ_op;
        logic   res_ld;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              occ_zero;
        logic              occ_full;
        logic              pos_gt_occ;
        logic              pos_ge_occ;
        logic              idx_gt_at;
        logic              idx_p1_lt_occ;
        logic              i_lt_occ;
        logic              idx_nz;
        logic              key_lt_rd;
        logic              out_free;
    } t_sts;

endpackage

### rtl/bss_datapath.sv
// Datapath: element memory, index counters, request and result registers.
`timescale 1ns / 1ps

module bss_datapath import bss_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    input  logic                     i_ready,
    output logic                     o_valid,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [STAT_W-1:0]        o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [FUNC_W-1:0]        r_func;
    logic [POS_W-1:0]         r_pos;
    logic signed [WORD_W-1:0] r_word;
    logic [CW-1:0]            r_occ;
    logic [CW-1:0]            r_idx;
    logic [CW-1:0]            r_at;
    logic [CW-1:0]            r_i;
    logic signed [WORD_W-1:0] r_key;
    logic signed [WORD_W-1:0] r_val;
    t_stat                    r_stat;
    logic signed [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0]        r_mem [CAPACITY];

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_word;
    t_stat                    r_out_stat;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_empty;

    logic [XW-1:0]            w_pos_x;
    logic [XW-1:0]            w_occ_x;
    logic [CW-1:0]            w_pos_c;
    logic [CW-1:0]            w_idx_m1;
    logic [CW-1:0]            w_idx_p1;
    logic [CW-1:0]            w_occ_m1;
    logic [CW-1:0]            w_rd_addr;
    logic [CW-1:0]            w_wr_addr;
    logic [WORD_W-1:0]        w_wr_data;

    assign w_pos_x  = XW'(r_pos);
    assign w_occ_x  = XW'(r_occ);
    assign w_pos_c  = w_pos_x[CW-1:0];
    assign w_idx_m1 = r_idx - 1'b1;
    assign w_idx_p1 = r_idx + 1'b1;
    assign w_occ_m1 = r_occ - 1'b1;

    always_comb begin
        case (i_cmd.rd_sel)
            A_ZERO:   w_rd_addr = '0;
            A_LAST:   w_rd_addr = w_occ_m1;
            A_POS:    w_rd_addr = w_pos_c;
            A_OCC:    w_rd_addr = r_occ;
            A_AT:     w_rd_addr = r_at;
            A_IDX:    w_rd_addr = r_idx;
            A_IDX_M1: w_rd_addr = w_idx_m1;
            A_IDX_P1: w_rd_addr = w_idx_p1;
            A_I:      w_rd_addr = r_i;
            default:  w_rd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            A_ZERO:   w_wr_addr = '0;
            A_LAST:   w_wr_addr = w_occ_m1;
            A_POS:    w_wr_addr = w_pos_c;
            A_OCC:    w_wr_addr = r_occ;
            A_AT:     w_wr_addr = r_at;
            A_IDX:    w_wr_addr = r_idx;
            A_IDX_M1: w_wr_addr = w_idx_m1;
            A_IDX_P1: w_wr_addr = w_idx_p1;
            A_I:      w_wr_addr = r_i;
            default:  w_wr_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            D_WORD:  w_wr_data = r_word;
            D_RD:    w_wr_data = r_rd_data;
            D_KEY:   w_wr_data = r_key;
            default: w_wr_data = r_word;
        endcase
    end

    // status toward the controller
    always_comb begin
        o_sts.func          = r_func;
        o_sts.occ_zero      = (r_occ == '0);
        o_sts.occ_full      = (r_occ >= CAP_C);
        o_sts.pos_gt_occ    = (w_pos_x > w_occ_x);
        o_sts.pos_ge_occ    = (w_pos_x >= w_occ_x);
        o_sts.idx_gt_at     = (r_idx > r_at);
        o_sts.idx_p1_lt_occ = (w_idx_p1 < r_occ);
        o_sts.i_lt_occ      = (r_i < r_occ);
        o_sts.idx_nz        = (r_idx != '0);
        o_sts.key_lt_rd     = (r_key < r_rd_data);
        o_sts.out_free      = !r_out_valid || i_ready;
    end

    // element memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr[AW-1:0]] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_ld) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_word <= i_word_in;
            r_val  <= '0;
        end else if (i_cmd.val_ld) begin
            r_val <= r_rd_data;
        end
        if (i_cmd.stat_ld) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.key_ld) begin
            r_key <= r_rd_data;
        end
        case (i_cmd.idx_op)
            IX_OCC:  r_idx <= r_occ;
            IX_AT:   r_idx <= r_at;
            IX_I:    r_idx <= r_i;
            IX_DEC:  r_idx <= w_idx_m1;
            IX_INC:  r_idx <= w_idx_p1;
            default: r_idx <= r_idx;
        endcase
        case (i_cmd.at_op)
            AT_ZERO: r_at <= '0;
            AT_POS:  r_at <= w_pos_c;
            default: r_at <= r_at;
        endcase
        case (i_cmd.i_op)
            I_ONE:   r_i <= CW'(1);
            I_INC:   r_i <= r_i + 1'b1;
            default: r_i <= r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            case (i_cmd.occ_op)
                OC_INC:  r_occ <= r_occ + 1'b1;
                OC_DEC:  r_occ <= w_occ_m1;
                OC_CLR:  r_occ <= '0;
                default: r_occ <= r_occ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_out_word  <= r_val;
            r_out_stat  <= r_stat;
            r_out_count <= w_occ_x[COUNT_W-1:0];
            r_out_empty <= (r_occ == '0);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_word_out = r_out_word;
    assign o_status   = r_out_stat;
    assign o_count    = r_out_count;
    assign o_is_empty = r_out_empty;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CAP_C)
        else $error("occupancy above capacity");

    a_rd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (w_rd_addr < r_occ))
        else $error("read of a slot beyond occupancy");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (w_wr_addr < CAP_C))
        else $error("write beyond capacity");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_occ) |-> (r_occ == $past(r_occ) + 1'b1 ||
                             $past(r_occ) == r_occ + 1'b1 || r_occ == '0))
        else $error("occupancy moved by more than one");

endmodule

### rtl/bss_ctrl.sv
// Controller: sequences each request over the datapath.
`timescale 1ns / 1ps

module bss_ctrl import bss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DEC    = 12'b0000_0000_0010,
        S_RD_CAP = 12'b0000_0000_0100,
        S_SU_CHK = 12'b0000_0000_1000,
        S_SU_WR  = 12'b0000_0001_0000,
        S_SD_CHK = 12'b0000_0010_0000,
        S_SD_WR  = 12'b0000_0100_0000,
        S_SO_OUT = 12'b0000_1000_0000,
        S_SO_KEY = 12'b0001_0000_0000,
        S_SO_CMP = 12'b0010_0000_0000,
        S_SO_TST = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.stat    = ST_OK;
        o_cmd.rd_sel  = A_ZERO;
        o_cmd.wr_sel  = A_ZERO;
        o_cmd.wd_sel  = D_WORD;
        o_cmd.idx_op  = IX_HOLD;
        o_cmd.at_op   = AT_HOLD;
        o_cmd.i_op    = I_HOLD;
        o_cmd.occ_op  = OC_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.req_ld = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.stat_ld = 1'b1;
                n_state       = S_DONE;
                case (i_sts.func)
                    OP_PUSH_BACK: begin
                        if (i_sts.occ_full) begin
                            o_cmd.stat = ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = A_OCC;
                            o_cmd.occ_op = OC_INC;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (i_sts.occ_full) begin
                            o_cmd.stat = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IX_OCC;
                            o_cmd.at_op  = AT_ZERO;
                            n_state      = S_SU_CHK;
                        end
                    end
                    OP_INSERT: begin
                        if (i_sts.pos_gt_occ) begin
                            o_cmd.stat = ST_MISS;
                        end else if (i_sts.occ_full) begin
                            o_cmd.stat = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IX_OCC;
                            o_cmd.at_op  = AT_POS;
                            n_state      = S_SU_CHK;
                        end
                    end
                    OP_POP_FRONT, OP_FRONT: begin
                        if (i_sts.occ_zero) begin
                            o_cmd.stat = ST_MISS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = A_ZERO;
                            o_cmd.at_op  = AT_ZERO;
                            n_state      = S_RD_CAP;
                        end
                    end
                    OP_POP_BACK, OP_BACK: begin
                        if (i_sts.occ_zero) begin
                            o_cmd.stat = ST_MISS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = A_LAST;
                            n_state      = S_RD_CAP;
                        end
                    end
                    OP_REMOVE, OP_READ_AT: begin
                        if (i_sts.pos_ge_occ) begin
                            o_cmd.stat = ST_MISS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = A_POS;
                            o_cmd.at_op  = AT_POS;
                            n_state      = S_RD_CAP;
                        end
                    end
                    OP_SORT: begin
                        o_cmd.i_op = I_ONE;
                        n_state    = S_SO_OUT;
                    end
                    OP_CLEAR: begin
                        o_cmd.occ_op = OC_CLR;
                    end
                    default: begin
                        o_cmd.stat = ST_MISS;
                    end
                endcase
            end
            S_RD_CAP: begin
                o_cmd.val_ld = 1'b1;
                n_state      = S_DONE;
                case (i_sts.func)
                    OP_POP_FRONT, OP_REMOVE: begin
                        o_cmd.idx_op = IX_AT;
                        n_state      = S_SD_CHK;
                    end
                    OP_POP_BACK: begin
                        o_cmd.occ_op = OC_DEC;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // open a gap at the target, moving entries up from the back
            S_SU_CHK: begin
                if (i_sts.idx_gt_at) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IDX_M1;
                    n_state      = S_SU_WR;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = A_AT;
                    o_cmd.wd_sel = D_WORD;
                    o_cmd.occ_op = OC_INC;
                    n_state      = S_DONE;
                end
            end
            S_SU_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_IDX;
                o_cmd.wd_sel = D_RD;
                o_cmd.idx_op = IX_DEC;
                n_state      = S_SU_CHK;
            end
            // close the gap, moving entries down toward the target
            S_SD_CHK: begin
                if (i_sts.idx_p1_lt_occ) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IDX_P1;
                    n_state      = S_SD_WR;
                end else begin
                    o_cmd.occ_op = OC_DEC;
                    n_state      = S_DONE;
                end
            end
            S_SD_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_IDX;
                o_cmd.wd_sel = D_RD;
                o_cmd.idx_op = IX_INC;
                n_state      = S_SD_CHK;
            end
            // insertion sort
            S_SO_OUT: begin
                if (i_sts.i_lt_occ) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_I;
                    o_cmd.idx_op = IX_I;
                    n_state      = S_SO_KEY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SO_KEY: begin
                o_cmd.key_ld = 1'b1;
                n_state      = S_SO_CMP;
            end
            S_SO_CMP: begin
                if (i_sts.idx_nz) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IDX_M1;
                    n_state      = S_SO_TST;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = A_IDX;
                    o_cmd.wd_sel = D_KEY;
                    o_cmd.i_op   = I_INC;
                    n_state      = S_SO_OUT;
                end
            end
            S_SO_TST: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_IDX;
                if (i_sts.key_lt_rd) begin
                    o_cmd.wd_sel = D_RD;
                    o_cmd.idx_op = IX_DEC;
                    n_state      = S_SO_CMP;
                end else begin
                    o_cmd.wd_sel = D_KEY;
                    o_cmd.i_op   = I_INC;
                    n_state      = S_SO_OUT;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bounded_sequence_store.sv
// Top level of the bounded sequence store.
`timescale 1ns / 1ps

// Bounded sequence store: an indexed double-ended queue of up to CAPACITY
// signed 32-bit words, kept in a single-port-write, single-port-read memory
// with registered read data. Each request carries an operation code, a
// position and a word; each request returns exactly one result with the
// value read (zero on error and for operations that read nothing), a
// status (ok, miss for empty, out-of-range or unused opcode, full), the
// element count after the operation and an empty flag. Requests are
// handled one at a time. Operations that move entries shift them one
// at a time through the memory ports: push front and insert move
// entries up from the back to open a gap, pop front and remove move
// entries down to close it. Sort is an insertion sort over the same
// ports. A finished result sits in an output register, and the next
// request is accepted while it waits to be taken. No clearing pass is
// needed after reset: slots beyond the count are never read.
module bounded_sequence_store import bss_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [STAT_W-1:0]        o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: decode, shift loops, sort loop, result handoff
    bss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage, index counters, compares and the result register
    bss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_func     (i_func),
        .i_position (i_position),
        .i_word_in  (i_word_in),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_word_out (o_word_out),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

endmodule

### verif/bounded_sequence_store_test.sv
// Self-checking testbench for the bounded sequence store, with its own mirror of the sequence.
`timescale 1ns / 1ps

module bounded_sequence_store_test;
    import bss_pkg::*;

    localparam int STORE_DEPTH = CAPACITY_DEF;
    // Longest quiet stretch between handshakes. It must cover a full
    // insertion sort over 64 reversed words and a receiver hold-off. This
    // limit leaves a wide margin over both.
    localparam int QUIET_LIMIT = 30000;
    localparam int HOLD_LEN    = 300;   // long receiver hold-off, in cycles
    localparam int HOLD_FIRST  = 300;   // request count at the first hold-off
    localparam int HOLD_EVERY  = 700;
    localparam int ITEMS_PHASE = 550;   // random requests per idling phase
    localparam int DRAIN_TAIL  = 20;

    // opcodes 11..15 are unused and must come back as a miss
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd11;
    localparam logic [FUNC_W-1:0] FUNC_TOP       = 4'd15;

    // shapes of the random request stream
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;
    localparam int MODE_FILL   = 3;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [STAT_W-1:0]  stat;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } seq_result_t;

    // Mirror of the sequence: it replays each accepted request and queues
    // the result that the store should return for it.
    class store_mirror;
        logic [WORD_W-1:0] slots [STORE_DEPTH];
        int unsigned       fill;
        seq_result_t       pending_results [$];
        int                errors;
        int                checked;
        int                full_seen;
        int                miss_seen;
        int                sorts;
        int unsigned       peak;

        function new();
            fill      = 0;
            errors    = 0;
            checked   = 0;
            full_seen = 0;
            miss_seen = 0;
            sorts     = 0;
            peak      = 0;
        endfunction

        task report(input string msg);
            if (errors < 60) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        function void note_request(input logic [FUNC_W-1:0] func,
                                   input logic [POS_W-1:0]  pos,
                                   input logic [WORD_W-1:0] word);
            seq_result_t       r;
            logic [WORD_W-1:0] key;
            int unsigned       i;
            int unsigned       j;
            r.word = '0;
            r.stat = ST_OK;
            case (func)
                OP_PUSH_BACK: begin
                    if (fill >= STORE_DEPTH) begin
                        r.stat = ST_FULL;
                    end else begin
                        slots[fill] = word;
                        fill++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (fill >= STORE_DEPTH) begin
                        r.stat = ST_FULL;
                    end else begin
                        for (i = fill; i > 0; i--) slots[i] = slots[i-1];
                        slots[0] = word;
                        fill++;
                    end
                end
                OP_POP_FRONT: begin
                    if (fill == 0) begin
                        r.stat = ST_MISS;
                    end else begin
                        r.word = slots[0];
                        for (i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
                        fill--;
                    end
                end
                OP_POP_BACK: begin
                    if (fill == 0) begin
                        r.stat = ST_MISS;
                    end else begin
                        r.word = slots[fill-1];
                        fill--;
                    end
                end
                OP_INSERT: begin
                    // past-the-end beats full
                    if (pos > fill) begin
                        r.stat = ST_MISS;
                    end else if (fill >= STORE_DEPTH) begin
                        r.stat = ST_FULL;
                    end else begin
                        for (i = fill; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos] = word;
                        fill++;
                    end
                end
                OP_REMOVE: begin
                    if (pos >= fill) begin
                        r.stat = ST_MISS;
                    end else begin
                        r.word = slots[pos];
                        for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                        fill--;
                    end
                end
                OP_READ_AT: begin
                    if (pos >= fill) r.stat = ST_MISS;
                    else             r.word = slots[pos];
                end
                OP_FRONT: begin
                    if (fill == 0) r.stat = ST_MISS;
                    else           r.word = slots[0];
                end
                OP_BACK: begin
                    if (fill == 0) r.stat = ST_MISS;
                    else           r.word = slots[fill-1];
                end
                OP_SORT: begin
                    // ascending as signed words, stable
                    for (i = 1; i < fill; i++) begin
                        key = slots[i];
                        j = i;
                        while (j > 0 && $signed(key) < $signed(slots[j-1])) begin
                            slots[j] = slots[j-1];
                            j--;
                        end
                        slots[j] = key;
                    end
                    sorts++;
                end
                OP_CLEAR: fill = 0;
                default:  r.stat = ST_MISS;
            endcase
            if (r.stat == ST_FULL) full_seen++;
            if (r.stat == ST_MISS) miss_seen++;
            if (fill > peak) peak = fill;
            r.count = COUNT_W'(fill);
            r.empty = (fill == 0);
            pending_results.push_back(r);
        endfunction

        task check_result(input logic [WORD_W-1:0]  word,
                          input logic [STAT_W-1:0]  stat,
                          input logic [COUNT_W-1:0] count,
                          input logic               empty);
            seq_result_t exp;
            if (pending_results.size() == 0) begin
                report($sformatf("result with no request outstanding (word %0d status %0d)",
                                 $signed(word), stat));
            end else begin
                exp = pending_results.pop_front();
                checked++;
                if (word !== exp.word)
                    report($sformatf("word_out %0d, want %0d",
                                     $signed(word), $signed(exp.word)));
                if (stat !== exp.stat)
                    report($sformatf("status %0d, want %0d", stat, exp.stat));
                if (count !== exp.count)
                    report($sformatf("count %0d, want %0d", count, exp.count));
                if (empty !== exp.empty)
                    report($sformatf("is_empty %0b, want %0b", empty, exp.empty));
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [FUNC_W-1:0]        i_func;
    logic [POS_W-1:0]         i_position;
    logic signed [WORD_W-1:0] i_word_in;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [WORD_W-1:0] o_word_out;
    logic [STAT_W-1:0]        o_status;
    logic [COUNT_W-1:0]       o_count;
    logic                     o_is_empty;

    store_mirror mirror;
    int          send_idle;     // percent of cycles the sender holds back
    int          rcv_idle;      // percent of cycles the receiver stalls
    int          n_accepted;    // requests taken by the store so far
    int          quiet_cycles;

    bounded_sequence_store #(
        .CAPACITY   (STORE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_position (i_position),
        .i_word_in  (i_word_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word_out (o_word_out),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Handshakes are sampled at the rising edge, before the store's own
    // registers move. Results are checked first, then the new request is
    // replayed on the mirror. A request's result never comes in its own cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_accepted = 0;
        end else begin
            if (o_valid && i_ready) begin
                mirror.check_result(o_word_out, o_status, o_count, o_is_empty);
            end
            if (i_valid && o_ready) begin
                mirror.note_request(i_func, i_position, i_word_in);
                n_accepted++;
            end
        end
    end

    // Watchdog: a stretch with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (o_valid && i_ready) || (i_valid && o_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, mirror.pending_results.size());
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side. It stalls at random, and now and then holds off for a
    // long stretch while the sender keeps offering. The store then fills
    // its output register and drops o_ready.
    initial begin
        int hold_left;
        int next_hold_at;
        i_ready      <= 1'b0;
        hold_left    = 0;
        next_hold_at = HOLD_FIRST;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && n_accepted >= next_hold_at) begin
                hold_left    = HOLD_LEN;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    // Offer one request and return at the falling edge after it is taken.
    // Valid stays high on return, so the caller either sends again at once
    // or drops valid itself.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [POS_W-1:0]  pos,
                                input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_position <= pos;
        i_word_in  <= word;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Sender pauses until every outstanding result has been taken.
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (mirror.pending_results.size() != 0);
    endtask

    // Idling knobs move just after a rising edge. The receiver reads them at
    // the falling edge.
    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(posedge i_clk);
        send_idle = sender_pct;
        rcv_idle  = receiver_pct;
        @(negedge i_clk);
    endtask

    // Random requests in blocks with a shape. Growing blocks enlarge the
    // sequence, fill blocks push it to capacity and beyond. Shrinking blocks
    // empty it again. Mixed blocks use every opcode, the unused ones included.
    // Positions mostly land inside the sequence or just past its end.
    task automatic run_random(input int n_items);
        int                done;
        int                left;
        int                mode;
        int                roll;
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        done = 0;
        left = 0;
        mode = MODE_MIX;
        while (done < n_items) begin
            if (left == 0) begin
                roll = $urandom_range(0, 99);
                if      (roll < 30) mode = MODE_GROW;
                else if (roll < 55) mode = MODE_SHRINK;
                else if (roll < 90) mode = MODE_MIX;
                else                mode = MODE_FILL;
                // a fill block runs until full, then this many extra requests
                left = (mode == MODE_FILL) ? $urandom_range(3, 6) : $urandom_range(20, 40);
            end

            roll = $urandom_range(0, 99);
            case (mode)
                MODE_GROW, MODE_FILL: begin
                    if      (roll < 30) func = OP_PUSH_BACK;
                    else if (roll < 55) func = OP_PUSH_FRONT;
                    else if (roll < 85) func = OP_INSERT;
                    else if (roll < 92) func = OP_READ_AT;
                    else if (roll < 96) func = OP_FRONT;
                    else                func = OP_BACK;
                end
                MODE_SHRINK: begin
                    if      (roll < 25) func = OP_POP_FRONT;
                    else if (roll < 50) func = OP_POP_BACK;
                    else if (roll < 80) func = OP_REMOVE;
                    else if (roll < 90) func = OP_READ_AT;
                    else if (roll < 95) func = OP_FRONT;
                    else                func = OP_BACK;
                end
                default: begin
                    if      (roll < 12) func = OP_PUSH_BACK;
                    else if (roll < 22) func = OP_PUSH_FRONT;
                    else if (roll < 32) func = OP_POP_FRONT;
                    else if (roll < 42) func = OP_POP_BACK;
                    else if (roll < 54) func = OP_INSERT;
                    else if (roll < 66) func = OP_REMOVE;
                    else if (roll < 78) func = OP_READ_AT;
                    else if (roll < 83) func = OP_FRONT;
                    else if (roll < 88) func = OP_BACK;
                    else if (roll < 93) func = OP_SORT;
                    else if (roll < 96) func = OP_CLEAR;
                    else func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_TOP));
                end
            endcase

            roll = $urandom_range(0, 99);
            if      (roll < 80) pos = POS_W'($urandom_range(0, mirror.fill));
            else if (roll < 90) pos = POS_W'($urandom_range(mirror.fill, mirror.fill + 2));
            else                pos = POS_W'($urandom_range(0, 127));

            // small values give sort plenty of duplicates to keep in order
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                word = $urandom;
            end else if (roll < 80) begin
                word = $urandom_range(0, 8) - 4;
            end else begin
                case ($urandom_range(0, 3))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7fff_ffff;
                    2:       word = 32'hffff_ffff;
                    default: word = 32'h0000_0000;
                endcase
            end

            send_request(func, pos, word);
            done++;
            if (mode != MODE_FILL || mirror.fill >= STORE_DEPTH) left--;
        end
    endtask

    initial begin
        mirror       = new();
        send_idle    = 6;
        rcv_idle     = 76;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= OP_PUSH_BACK;
        i_position <= '0;
        i_word_in  <= '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: all but the pushes on an empty store, then a short
        // sequence with extreme words. Covers insert past the end, insert at
        // count (acts as an append), reads out of range, and unused opcodes.
        send_request(OP_CLEAR,      7'd0,   32'h0);
        send_request(OP_POP_FRONT,  7'd0,   32'h0);
        send_request(OP_POP_BACK,   7'd0,   32'h0);
        send_request(OP_FRONT,      7'd0,   32'h0);
        send_request(OP_BACK,       7'd0,   32'h0);
        send_request(OP_READ_AT,    7'd0,   32'h0);
        send_request(OP_REMOVE,     7'd0,   32'h0);
        send_request(OP_SORT,       7'd0,   32'h0);
        send_request(OP_INSERT,     7'd1,   32'h1234_5678);
        send_request(OP_INSERT,     7'd0,   32'h7fff_ffff);
        send_request(OP_PUSH_BACK,  7'd127, 32'h8000_0000);
        send_request(OP_PUSH_FRONT, 7'd0,   32'hffff_ffff);
        send_request(OP_INSERT,     7'd3,   32'h0);
        send_request(OP_READ_AT,    7'd127, 32'h0);
        send_request(OP_READ_AT,    7'd4,   32'h0);
        send_request(OP_FRONT,      7'd0,   32'h0);
        send_request(OP_BACK,       7'd0,   32'h0);
        send_request(FUNC_UNUSED_LO, 7'd0,  32'hffff_ffff);
        send_request(FUNC_TOP,      7'd127, 32'hffff_ffff);
        send_request(OP_SORT,       7'd0,   32'h0);
        send_request(OP_REMOVE,     7'd1,   32'h0);
        send_request(OP_REMOVE,     7'd3,   32'h0);
        send_request(OP_POP_FRONT,  7'd0,   32'h0);
        send_request(OP_POP_BACK,   7'd0,   32'h0);
        send_request(OP_CLEAR,      7'd0,   32'h0);

        // Three idling phases: a mostly stalled receiver, then a mostly idle
        // sender, then full rate. Each phase ends with a full drain.
        run_random(ITEMS_PHASE);
        wait_drain();
        set_idling(76, 6);
        run_random(ITEMS_PHASE);
        wait_drain();
        set_idling(0, 0);
        run_random(ITEMS_PHASE);
        wait_drain();
        repeat (DRAIN_TAIL) @(negedge i_clk);

        $display("Run covered %0d requests and %0d checked results, in three idling phases.",
                 n_accepted, mirror.checked);
        $display("Store reached %0d entries; %0d full refusals, %0d misses, %0d sorts.",
                 mirror.peak, mirror.full_seen, mirror.miss_seen, mirror.sorts);
        if (mirror.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
